### sv/multi_voice_sample_mixer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-voice sample mixer
// Shared property forms; each expects clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef MULTI_VOICE_SAMPLE_MIXER_CORE_DEFINES_SVH
`define MULTI_VOICE_SAMPLE_MIXER_CORE_DEFINES_SVH

// same-cycle implication
`define MVSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MVSM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mvsm_pkg.sv
// ----------------------------------------------------------------------------
// mvsm_pkg
// Types and fixed constants of the multi-voice sample mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mvsm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 16;
    localparam int LEN_W       = 17;
    localparam int PROD_W      = 33;
    localparam int SCALE_SHIFT = 29;
    localparam int STEP_W      = 4;
    localparam int CNT_OUT_W   = 4;
    localparam int ADDR_IN_W   = 16;
    localparam int IN_TDATA_W  = 88;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = 3;
    localparam int CFG_W       = 2;

    localparam logic [CFG_W-1:0]           CFG_RESET     = 2'd2;
    localparam logic [CFG_W-1:0]           MONO_CHANNELS = 2'd1;
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX       = 16'sd32767;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_MIX   = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic              valid;
        logic              ending;
        logic [GAIN_W-1:0] gain;
    } voice_stat_t;

    typedef struct packed {
        logic clear;
        logic mac_en;
        logic scale_go;
    } chan_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } chan_stat_t;

    typedef struct packed {
        logic                       is_mix;
        logic                       ok;
        logic [CNT_OUT_W-1:0]       count;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } mix_result_t;

endpackage

`default_nettype wire

### sv/mvsm_voice_lane.sv
// ----------------------------------------------------------------------------
// mvsm_voice_lane
// State of one voice slot: read address, position, length, loop and gain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvsm_voice_lane
    import mvsm_pkg::*;
#(
    parameter int MEM_AW        = 16,
    parameter int SAMPLE_FRAMES = 65536
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [MEM_AW-1:0] start_addr,
    input  wire logic [LEN_W-1:0]  start_len,
    input  wire logic              start_loop,
    input  wire logic [GAIN_W-1:0] start_gain,
    input  wire logic              advance,
    output voice_stat_t            stat,
    output logic [MEM_AW-1:0]      rd_addr
);

    localparam logic [MEM_AW-1:0] ADDR_LAST = MEM_AW'(SAMPLE_FRAMES - 1);

    logic              valid_reg;
    logic              valid_next;
    logic [MEM_AW-1:0] base_reg;
    logic [MEM_AW-1:0] addr_reg;
    logic [MEM_AW-1:0] addr_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  pos_reg;
    logic [LEN_W-1:0]  pos_next;
    logic              loop_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [LEN_W-1:0]  pos_inc;
    logic              last;

    assign pos_inc = pos_reg + LEN_W'(1);
    assign last    = (pos_inc >= len_reg);

    always_comb
    begin
        valid_next = valid_reg;
        pos_next   = pos_reg;
        addr_next  = addr_reg;
        if (start)
        begin
            valid_next = 1'b1;
            pos_next   = '0;
            addr_next  = start_addr;
        end
        else if (advance)
        begin
            if (last)
            begin
                pos_next  = '0;
                addr_next = base_reg;
                if (!loop_reg)
                begin
                    valid_next = 1'b0;
                end
            end
            else
            begin
                pos_next  = pos_inc;
                addr_next = (addr_reg == ADDR_LAST) ? '0 : addr_reg + MEM_AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        addr_reg <= addr_next;
        if (start)
        begin
            base_reg <= start_addr;
            len_reg  <= start_len;
            loop_reg <= start_loop;
            gain_reg <= start_gain;
        end
    end

    assign stat.valid  = valid_reg;
    assign stat.ending = valid_reg && last && !loop_reg;
    assign stat.gain   = gain_reg;
    assign rd_addr     = addr_reg;

endmodule

`default_nettype wire

### sv/mvsm_chan_lane.sv
// ----------------------------------------------------------------------------
// mvsm_chan_lane
// One output channel: multiply-accumulate, then scale, round and saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvsm_chan_lane
    import mvsm_pkg::*;
#(
    parameter int ACC_W = 36
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  chan_ctrl_t                      ctrl,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic [GAIN_W-1:0]          gain,
    output chan_stat_t                      stat,
    output logic signed [SAMPLE_W-1:0]      result
);

    localparam logic signed [ACC_W-1:0] HALF_POS = ACC_W'(64'sd1 <<< SCALE_SHIFT);
    localparam logic signed [ACC_W-1:0] HALF_NEG = -HALF_POS;
    localparam int                      Q_W      = SAMPLE_W - 1;
    localparam int                      M_W      = SCALE_SHIFT + Q_W;

    logic signed [PROD_W-1:0]   prod_reg;
    logic                       prod_v_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       s1_v_reg;
    logic                       sat_pos_reg;
    logic                       sat_neg_reg;
    logic                       neg_reg;
    logic [SCALE_SHIFT-1:0]     mag_reg;
    logic                       done_reg;
    logic signed [SAMPLE_W-1:0] result_reg;
    logic signed [SAMPLE_W-1:0] result_next;
    logic signed [ACC_W-1:0]    acc_abs;
    logic [M_W-1:0]             m_full;
    logic [Q_W-1:0]             q_raw;
    logic [SCALE_SHIFT-1:0]     r_raw;
    logic                       round_up;
    logic [Q_W-1:0]             q_rnd;

    assign acc_abs = (acc_reg < 0) ? -acc_reg : acc_reg;

    // 32767 * mag as (mag << 15) - mag
    assign m_full   = {mag_reg, {Q_W{1'b0}}} - M_W'(mag_reg);
    assign q_raw    = m_full[M_W-1:SCALE_SHIFT];
    assign r_raw    = m_full[SCALE_SHIFT-1:0];
    assign round_up = r_raw[SCALE_SHIFT-1]
                      && ((r_raw[SCALE_SHIFT-2:0] != '0) || q_raw[0]);
    assign q_rnd    = q_raw + Q_W'(round_up);

    always_comb
    begin
        if (sat_pos_reg)
        begin
            result_next = OUT_MAX;
        end
        else if (sat_neg_reg)
        begin
            result_next = -OUT_MAX;
        end
        else if (neg_reg)
        begin
            result_next = -$signed({1'b0, q_rnd});
        end
        else
        begin
            result_next = $signed({1'b0, q_rnd});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
            s1_v_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            prod_v_reg <= ctrl.mac_en;
            s1_v_reg   <= ctrl.scale_go;
            done_reg   <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= sample * $signed({1'b0, gain});
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (ctrl.scale_go)
        begin
            sat_pos_reg <= (acc_reg >= HALF_POS);
            sat_neg_reg <= (acc_reg <= HALF_NEG);
            neg_reg     <= (acc_reg < 0);
            mag_reg     <= acc_abs[SCALE_SHIFT-1:0];
        end
        if (s1_v_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign stat.busy = prod_v_reg;
    assign stat.done = done_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

### sv/mvsm_merge.sv
// ----------------------------------------------------------------------------
// mvsm_merge
// Combine both channel results with status into the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvsm_merge
    import mvsm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire logic                    mono,
    input  mix_result_t                  res,
    output logic                         free,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]       m_axis_tdata
);

    logic                       tvalid_reg;
    logic                       tvalid_next;
    logic [OUT_TDATA_W-1:0]     tdata_reg;
    logic [OUT_TDATA_W-1:0]     tdata_next;
    logic signed [SAMPLE_W-1:0] left_m;
    logic signed [SAMPLE_W-1:0] right_m;

    assign free    = !tvalid_reg || m_axis_tready;
    assign left_m  = res.is_mix ? res.left : '0;
    assign right_m = (res.is_mix && !mono) ? res.right : '0;

    always_comb
    begin
        tvalid_next = tvalid_reg;
        tdata_next  = tdata_reg;
        if (load)
        begin
            tvalid_next = 1'b1;
            tdata_next  = {{OUT_PAD_W{1'b0}}, res.count, res.ok, right_m, left_m};
        end
        else if (m_axis_tready)
        begin
            tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
        end
        else
        begin
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tdata_reg <= tdata_next;
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;

endmodule

`default_nettype wire

### sv/multi_voice_sample_mixer_core.sv
// Write or start: the address is reduced modulo SAMPLE_FRAMES in R restoring steps, then
//   committed; R = 0 at the default size. The next item is taken only after the output word loads.
// Mix: the single sample memory read port walks the voice slots one per cycle, then both
//   channel lanes scale their sums; the next item is taken only after the output word loads.
// Reset (rst_n, async, active low) frees all voices, empties the output register and
//   sets channel_count to 2; sample memory is not cleared.
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer_core
// Stereo sample-playback mixer: sample memory, voice slots, channel lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_voice_sample_mixer_core
    import mvsm_pkg::*;
#(
    parameter int VOICES        = 8,
    parameter int SAMPLE_FRAMES = 65536
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_W-1:0]       cfg_wdata,      // channel_count
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // address, sample_left, sample_right, length_frames, loop_enable, volume
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,   // opcode
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // out_left, out_right, accepted, active_voices
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    function automatic int red_steps_f(input longint frames);
        int s;
        s = 0;
        while ((frames << s) < 65536)
        begin
            s = s + 1;
        end
        return s;
    endfunction

    localparam int MEM_AW    = $clog2(SAMPLE_FRAMES);
    localparam int VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W     = $clog2(VOICES + 1);
    localparam int ACC_W     = PROD_W + $clog2(VOICES);
    localparam int RED_STEPS = red_steps_f(longint'(SAMPLE_FRAMES));

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REDUCE = 6'b000010,
        ST_COMMIT = 6'b000100,
        ST_MIX    = 6'b001000,
        ST_SCALE  = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    opcode_t                    in_op;
    logic [ADDR_IN_W-1:0]       in_addr;
    logic [SAMPLE_W-1:0]        in_left;
    logic [SAMPLE_W-1:0]        in_right;
    logic [LEN_W-1:0]           in_len;
    logic                       in_loop;
    logic [GAIN_W-1:0]          in_vol;
    logic                       accept;

    opcode_t                    op_reg;
    logic [SAMPLE_W-1:0]        left_reg;
    logic [SAMPLE_W-1:0]        right_reg;
    logic [LEN_W-1:0]           len_reg;
    logic                       loop_reg;
    logic [GAIN_W-1:0]          vol_reg;
    logic [ADDR_IN_W-1:0]       red_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [LEN_W-1:0]           red_sub;
    logic [LEN_W-1:0]           red_diff;

    logic [CFG_W-1:0]           chan_cnt_reg;
    logic [VIDX_W-1:0]          idx_reg;
    logic                       issue_done_reg;
    logic                       rd_v_reg;
    logic [GAIN_W-1:0]          gain_pipe_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       ok_reg;

    logic [31:0]                sample_mem [SAMPLE_FRAMES];
    logic [31:0]                rdata_reg;
    logic                       mem_we;
    logic [MEM_AW-1:0]          red_addr;

    voice_stat_t                vstat [VOICES];
    logic [MEM_AW-1:0]          vaddr [VOICES];
    voice_stat_t                sel_stat;
    logic [MEM_AW-1:0]          sel_addr;
    logic [VIDX_W-1:0]          free_slot;
    logic                       slot_found;
    logic                       alloc_fire;
    logic                       issuing;
    logic                       mix_empty;

    chan_ctrl_t                 cctrl;
    chan_stat_t                 cstat_l;
    chan_stat_t                 cstat_r;
    logic signed [SAMPLE_W-1:0] res_l;
    logic signed [SAMPLE_W-1:0] res_r;
    mix_result_t                mres;
    logic                       out_free;
    logic                       out_load;

    assign in_op    = opcode_t'(s_axis_tuser[1:0]);
    assign in_addr  = s_axis_tdata[15:0];
    assign in_left  = s_axis_tdata[31:16];
    assign in_right = s_axis_tdata[47:32];
    assign in_len   = s_axis_tdata[64:48];
    assign in_loop  = s_axis_tdata[65];
    assign in_vol   = s_axis_tdata[81:66];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // restoring reduction of the address modulo SAMPLE_FRAMES
    assign red_sub  = LEN_W'(SAMPLE_FRAMES) << step_reg;
    assign red_diff = {1'b0, red_reg} - red_sub;
    assign red_addr = MEM_AW'(red_reg);

    always_comb
    begin
        free_slot  = '0;
        slot_found = 1'b0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!vstat[i].valid)
            begin
                free_slot  = VIDX_W'(i);
                slot_found = 1'b1;
            end
        end
    end

    assign alloc_fire = (state_reg == ST_COMMIT) && (op_reg == OP_START)
                        && (len_reg != '0) && slot_found;
    assign mem_we     = (state_reg == ST_COMMIT) && (op_reg == OP_WRITE);
    assign issuing    = (state_reg == ST_MIX) && !issue_done_reg;
    assign sel_stat   = vstat[idx_reg];
    assign sel_addr   = vaddr[idx_reg];
    assign mix_empty  = issue_done_reg && !rd_v_reg && !cstat_l.busy && !cstat_r.busy;
    assign out_load   = (state_reg == ST_DONE) && out_free;

    assign cctrl.clear    = accept && (in_op == OP_MIX);
    assign cctrl.mac_en   = rd_v_reg;
    assign cctrl.scale_go = (state_reg == ST_MIX) && mix_empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_WRITE, OP_START:
                            state_next = (RED_STEPS == 0) ? ST_COMMIT : ST_REDUCE;
                        OP_MIX:
                            state_next = ST_MIX;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_REDUCE:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_DONE;
            end
            ST_MIX:
            begin
                if (mix_empty)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (cstat_l.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            chan_cnt_reg   <= CFG_RESET;
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            rd_v_reg       <= 1'b0;
            count_reg      <= '0;
            ok_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= issuing && sel_stat.valid;
            if (cfg_we)
            begin
                chan_cnt_reg <= cfg_wdata;
            end
            if (accept)
            begin
                ok_reg         <= (in_op == OP_WRITE) || (in_op == OP_MIX);
                idx_reg        <= '0;
                issue_done_reg <= 1'b0;
            end
            else if (issuing)
            begin
                idx_reg <= idx_reg + VIDX_W'(1);
                if (idx_reg == VIDX_W'(VOICES - 1))
                begin
                    issue_done_reg <= 1'b1;
                end
            end
            if ((state_reg == ST_COMMIT) && (op_reg == OP_START))
            begin
                ok_reg <= alloc_fire;
            end
            if (alloc_fire)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (issuing && sel_stat.ending)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_op;
            left_reg  <= in_left;
            right_reg <= in_right;
            len_reg   <= in_len;
            loop_reg  <= in_loop;
            vol_reg   <= in_vol;
            red_reg   <= in_addr;
            step_reg  <= STEP_W'(RED_STEPS - 1);
        end
        else if (state_reg == ST_REDUCE)
        begin
            if ({1'b0, red_reg} >= red_sub)
            begin
                red_reg <= red_diff[ADDR_IN_W-1:0];
            end
            step_reg <= step_reg - STEP_W'(1);
        end
        gain_pipe_reg <= sel_stat.gain;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[red_addr] <= {right_reg, left_reg};
        end
        rdata_reg <= sample_mem[sel_addr];
    end

    for (genvar g = 0; g < VOICES; g++)
    begin : g_voice
        mvsm_voice_lane #(
            .MEM_AW        (MEM_AW),
            .SAMPLE_FRAMES (SAMPLE_FRAMES)
        ) u_voice (
            .clk        (clk),
            .rst_n      (rst_n),
            .start      (alloc_fire && (free_slot == VIDX_W'(g))),
            .start_addr (red_addr),
            .start_len  (len_reg),
            .start_loop (loop_reg),
            .start_gain (vol_reg),
            .advance    (issuing && (idx_reg == VIDX_W'(g)) && vstat[g].valid),
            .stat       (vstat[g]),
            .rd_addr    (vaddr[g])
        );
    end

    mvsm_chan_lane #(
        .ACC_W (ACC_W)
    ) u_chan_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (cctrl),
        .sample ($signed(rdata_reg[15:0])),
        .gain   (gain_pipe_reg),
        .stat   (cstat_l),
        .result (res_l)
    );

    mvsm_chan_lane #(
        .ACC_W (ACC_W)
    ) u_chan_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (cctrl),
        .sample ($signed(rdata_reg[31:16])),
        .gain   (gain_pipe_reg),
        .stat   (cstat_r),
        .result (res_r)
    );

    assign mres.is_mix = (op_reg == OP_MIX);
    assign mres.ok     = ok_reg;
    assign mres.count  = CNT_OUT_W'(count_reg);
    assign mres.left   = res_l;
    assign mres.right  = res_r;

    mvsm_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .mono          (chan_cnt_reg == MONO_CHANNELS),
        .res           (mres),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

### sv/mvsm_checker.sv
// ----------------------------------------------------------------------------
// mvsm_checker
// Port-level checks of the mixer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "multi_voice_sample_mixer_core_defines.svh"

module mvsm_checker
    import mvsm_pkg::*;
#(
    parameter int VOICES = 8
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    `MVSM_ASSERT_IMP(a_reject_zero, m_axis_tvalid && !m_axis_tdata[32],
        m_axis_tdata[31:0] == 32'd0, "rejected or idle word carries nonzero samples")

    `MVSM_ASSERT_IMP(a_sat_range, m_axis_tvalid,
        (m_axis_tdata[15:0] != 16'h8000) && (m_axis_tdata[31:16] != 16'h8000),
        "output sample outside saturation range")

    `MVSM_ASSERT_IMP(a_voice_count, m_axis_tvalid,
        (VOICES >= 16) || (m_axis_tdata[36:33] <= 4'(VOICES)),
        "active voice count above slot count")

    `MVSM_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "input taken again while an item is in work")

    `MVSM_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled output word changed")

endmodule

bind multi_voice_sample_mixer_core mvsm_checker #(
    .VOICES (VOICES)
) u_mvsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
